FILE: src/wsr_pkg.sv
// Shared types, constants and tables for the wind sway rotation block.
// Used by the channel interfaces, the serial ALU and the top level.
`default_nettype none

package wsr_pkg;

   localparam int NUM_MATRICES_DEF = 4;
   localparam int OUT_FRAC_DEF     = 15;

   localparam int ACC_W  = 64;
   localparam int OPB_W  = 32;
   localparam int DIVR_W = 16;
   localparam int CNT_W  = 7;

   localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
   localparam logic [32:0] TWO_PI_Q30  = 33'd6746518852;
   localparam logic [21:0] INV_2PI_Q24 = 22'd2670177;
   localparam logic [15:0] TILT_DIVISOR = 16'd360;

   // quotient bits of each division
   localparam logic [CNT_W-1:0] RESCALE_DIV_BITS = 7'd48;
   localparam logic [CNT_W-1:0] TILT_DIV_BITS    = 7'd52;
   localparam logic [CNT_W-1:0] HORNER_DIV_BITS  = 7'd31;

   typedef enum logic [0:0] {
      ALU_MUL = 1'b0,
      ALU_DIV = 1'b1
   } alu_op_type;

   typedef struct packed {
      logic             start;
      alu_op_type       op;
      logic [ACC_W-1:0] a;      // multiplicand or dividend
      logic [OPB_W-1:0] b;      // multiplier or divisor
      logic [CNT_W-1:0] nbits;  // dividend width for a division
   } alu_req_type;

   typedef struct packed {
      logic             done;
      logic [ACC_W-1:0] result;
   } alu_rsp_type;

   // 20 * sway frequency (Q0.16) per matrix; axis 0 is x, 1 is y
   function automatic logic [18:0] freq20(input logic axis, input logic [1:0] k);
      logic [18:0] f;
      f = '0;
      case ({axis, k})
         3'b000:  f = 19'd196600;
         3'b001:  f = 19'd327680;
         3'b010:  f = 19'd249040;
         3'b011:  f = 19'd196600;
         3'b100:  f = 19'd222820;
         3'b101:  f = 19'd196600;
         3'b110:  f = 19'd65540;
         3'b111:  f = 19'd288360;
         default: f = '0;
      endcase
      return f;
   endfunction

   // Horner divisors: sine series first, then cosine series
   function automatic logic [15:0] horner_div(input logic [2:0] step);
      logic [15:0] d;
      d = 16'd1;
      case (step)
         3'd0:    d = 16'd72;
         3'd1:    d = 16'd42;
         3'd2:    d = 16'd20;
         3'd3:    d = 16'd6;
         3'd4:    d = 16'd56;
         3'd5:    d = 16'd30;
         3'd6:    d = 16'd12;
         3'd7:    d = 16'd2;
         default: d = 16'd1;
      endcase
      return d;
   endfunction

endpackage

`default_nettype wire

FILE: src/wsr_channels.sv
// Valid/ready channel interfaces: time request, matrix response, strength write.
// Depends on wsr_pkg.
`default_nettype none

interface wsr_req_if import wsr_pkg::*; ();
   logic        valid;
   logic        ready;
   logic [31:0] current_time;
   modport source (output valid, output current_time, input ready);
   modport sink   (input valid, input current_time, output ready);
endinterface

interface wsr_rsp_if import wsr_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [1:0]         matrix_index;
   logic signed [15:0] cos_tilt_y;
   logic signed [15:0] neg_sin_tilt_y;
   logic signed [15:0] sinx_times_siny;
   logic signed [15:0] cos_tilt_x;
   logic signed [15:0] sinx_times_cosy;
   logic signed [15:0] siny_times_cosx;
   logic signed [15:0] neg_sin_tilt_x;
   logic signed [15:0] cosx_times_cosy;
   logic               last_matrix;
   modport source (output valid, output matrix_index, output cos_tilt_y,
                   output neg_sin_tilt_y, output sinx_times_siny, output cos_tilt_x,
                   output sinx_times_cosy, output siny_times_cosx,
                   output neg_sin_tilt_x, output cosx_times_cosy,
                   output last_matrix, input ready);
   modport sink   (input valid, input matrix_index, input cos_tilt_y,
                   input neg_sin_tilt_y, input sinx_times_siny, input cos_tilt_x,
                   input sinx_times_cosy, input siny_times_cosx,
                   input neg_sin_tilt_x, input cosx_times_cosy,
                   input last_matrix, output ready);
endinterface

interface wsr_csr_if import wsr_pkg::*; ();
   logic        valid;
   logic        ready;
   logic [15:0] wind_strength;
   modport source (output valid, output wind_strength, input ready);
   modport sink   (input valid, input wind_strength, output ready);
endinterface

`default_nettype wire

FILE: src/wsr_serial_alu.sv
// Bit-serial multiply (shift-add, stops when the multiplier runs out) and
// restoring divide (one quotient bit per cycle). Depends on wsr_pkg.
`default_nettype none

module wsr_serial_alu import wsr_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire alu_req_type req,
   output alu_rsp_type      rsp
);

   logic             busy_ff, busy_in;
   alu_op_type       op_ff, op_in;
   logic [ACC_W-1:0] acc_ff, acc_in;
   logic [ACC_W-1:0] a_ff, a_in;     // multiplicand, or dividend/quotient shifter
   logic [OPB_W-1:0] b_ff, b_in;
   logic [DIVR_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIVR_W:0]  trial;
   logic             finish;

   assign finish = busy_ff && ((op_ff == ALU_MUL) ? (b_ff == '0) : (cnt_ff == '0));
   assign rsp.done = finish;
   assign rsp.result = (op_ff == ALU_MUL) ? acc_ff : a_ff;
   assign trial = {rem_ff, a_ff[ACC_W-1]};

   always_comb begin
      busy_in = busy_ff;
      op_in   = op_ff;
      acc_in  = acc_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      if (!busy_ff) begin
         if (req.start) begin
            busy_in = 1'b1;
            op_in   = req.op;
            acc_in  = '0;
            b_in    = req.b;
            rem_in  = '0;
            cnt_in  = req.nbits;
            if (req.op == ALU_MUL) begin
               a_in = req.a;
            end else begin
               a_in = req.a << (7'd64 - req.nbits);
            end
         end
      end else if (finish) begin
         busy_in = 1'b0;
      end else if (op_ff == ALU_MUL) begin
         if (b_ff[0]) begin
            acc_in = acc_ff + a_ff;
         end
         a_in = {a_ff[ACC_W-2:0], 1'b0};
         b_in = {1'b0, b_ff[OPB_W-1:1]};
      end else begin
         if (trial >= {1'b0, b_ff[DIVR_W-1:0]}) begin
            rem_in = DIVR_W'(trial - {1'b0, b_ff[DIVR_W-1:0]});
            a_in   = {a_ff[ACC_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DIVR_W-1:0];
            a_in   = {a_ff[ACC_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
   end

endmodule

`default_nettype wire

FILE: src/wind_sway_rotation_matrices.sv
// Wind sway rotation matrices: one time word in, NUM_MATRICES matrix words out.
// All arithmetic runs through one bit-serial multiply/divide unit; four sin/cos
// Horner evaluations dominate the work of each matrix. The next time word is taken
// once the last matrix word sits in the output register.
// Reset (synchronous): strength, previous strength, previous time and timers clear.
`default_nettype none

module wind_sway_rotation_matrices import wsr_pkg::*; #(
   parameter int NUM_MATRICES         = NUM_MATRICES_DEF,
   parameter int OUTPUT_FRACTION_BITS = OUT_FRAC_DEF
) (
   input wire logic clock,
   input wire logic reset,
   wsr_req_if.sink   req_chan,
   wsr_rsp_if.source rsp_chan,
   wsr_csr_if.sink   csr_chan
);

   localparam int SH = 30 - OUTPUT_FRACTION_BITS;
   localparam logic [32:0] RND     = (SH > 0) ? (33'd1 << (SH - 1)) : 33'd0;
   localparam logic [32:0] LIM_POS = (33'd1 << OUTPUT_FRACTION_BITS) - 33'd1;
   localparam logic [32:0] LIM_NEG = 33'd1 << OUTPUT_FRACTION_BITS;
   localparam logic [1:0]  LAST_K  = 2'(NUM_MATRICES - 1);

   typedef enum logic [15:0] {
      ST_IDLE    = 16'h0001,
      ST_LOAD    = 16'h0002,
      ST_RS_MUL  = 16'h0004,
      ST_RS_DIV  = 16'h0008,
      ST_FQ_W    = 16'h0010,
      ST_FQ_RATE = 16'h0020,
      ST_FQ_PH   = 16'h0040,
      ST_TL_MUL  = 16'h0080,
      ST_TL_DIV  = 16'h0100,
      ST_SC_M    = 16'h0200,
      ST_SC_X2   = 16'h0400,
      ST_SC_HMUL = 16'h0800,
      ST_SC_HDIV = 16'h1000,
      ST_SC_S    = 16'h2000,
      ST_PR_MUL  = 16'h4000,
      ST_EMIT    = 16'h8000
   } state_type;

   typedef struct packed {
      logic [1:0]  matrix_index;
      logic [15:0] cos_tilt_y;
      logic [15:0] neg_sin_tilt_y;
      logic [15:0] sinx_times_siny;
      logic [15:0] cos_tilt_x;
      logic [15:0] sinx_times_cosy;
      logic [15:0] siny_times_cosx;
      logic [15:0] neg_sin_tilt_x;
      logic [15:0] cosx_times_cosy;
      logic        last_matrix;
   } out_word_type;

   function automatic logic [15:0] to_out(input logic signed [31:0] v);
      logic        neg;
      logic [32:0] mg;
      logic [32:0] lim;
      logic [32:0] r;
      neg = v[31];
      mg  = neg ? (33'd0 - {v[31], v}) : {1'b0, v};
      r   = (mg + RND) >> SH;
      lim = neg ? LIM_NEG : LIM_POS;
      if (r > lim) begin
         r = lim;
      end
      r = neg ? (33'd0 - r) : r;
      return r[15:0];
   endfunction

   state_type    state_ff, state_in;
   logic         issued_ff, issued_in;
   logic [15:0]  strength_ff, strength_in;
   logic [15:0]  prev_strength_ff, prev_strength_in;
   logic [31:0]  prev_time_ff, prev_time_in;
   logic [31:0]  timers_ff [4];
   logic [31:0]  timers_in [4];
   logic [1:0]   k_ff, k_in;
   logic [1:0]   call_ff, call_in;
   logic [2:0]   step_ff, step_in;
   logic [1:0]   pr_ff, pr_in;
   logic         rsp_valid_ff, rsp_valid_in;

   logic [31:0]  elapsed_ff, elapsed_in;
   logic [31:0]  timer_ff, timer_in;
   logic [63:0]  tmp_ff, tmp_in;
   logic [31:0]  phase_ff, phase_in;
   logic [29:0]  x_ff, x_in;
   logic [29:0]  x2_ff, x2_in;
   logic [30:0]  t_ff, t_in;
   logic [30:0]  u_ff, u_in;
   logic signed [31:0] px_ff, px_in, py_ff, py_in;
   logic signed [31:0] sx_ff, sx_in, cx_ff, cx_in;
   logic signed [31:0] sy_ff, sy_in, cy_ff, cy_in;
   logic signed [31:0] prod_ff [4];
   logic signed [31:0] prod_in [4];
   out_word_type out_ff, out_in;

   alu_req_type  alu_req;
   alu_rsp_type  alu_rsp;

   // phase reduction to nearest quarter turn
   logic [31:0]  q_sum;
   logic [1:0]   quad;
   logic [31:0]  red;
   logic         red_neg;
   logic [31:0]  red_mag;
   // tilt source
   logic signed [31:0] pct;
   logic [31:0]  pct_mag;
   logic [21:0]  s35;
   // product operands
   logic signed [31:0] opa, opb;
   logic [31:0]  opa_mag, opb_mag;
   // sincos finish
   logic [31:0]  s_mag;
   logic signed [31:0] s_sgn, c_sgn, sin_out, cos_out;
   logic [31:0]  tl_mag;
   logic [31:0]  pr_mag;
   logic [31:0]  timer_sum;
   logic [30:0]  horner_q;
   logic         is_op;

   wsr_serial_alu u_alu (
      .clock (clock),
      .reset (reset),
      .req   (alu_req),
      .rsp   (alu_rsp)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign csr_chan.ready = 1'b1;

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.matrix_index    = out_ff.matrix_index;
   assign rsp_chan.cos_tilt_y      = out_ff.cos_tilt_y;
   assign rsp_chan.neg_sin_tilt_y  = out_ff.neg_sin_tilt_y;
   assign rsp_chan.sinx_times_siny = out_ff.sinx_times_siny;
   assign rsp_chan.cos_tilt_x      = out_ff.cos_tilt_x;
   assign rsp_chan.sinx_times_cosy = out_ff.sinx_times_cosy;
   assign rsp_chan.siny_times_cosx = out_ff.siny_times_cosx;
   assign rsp_chan.neg_sin_tilt_x  = out_ff.neg_sin_tilt_x;
   assign rsp_chan.cosx_times_cosy = out_ff.cosx_times_cosy;
   assign rsp_chan.last_matrix     = out_ff.last_matrix;

   always_comb begin
      q_sum   = phase_ff + 32'h2000_0000;
      quad    = q_sum[31:30];
      red     = phase_ff - {quad, 30'd0};
      red_neg = red[31];
      red_mag = red_neg ? (32'd0 - red) : red;

      pct     = call_ff[0] ? py_ff : px_ff;
      pct_mag = pct[31] ? (32'd0 - pct) : pct;
      s35     = {1'b0, strength_ff, 5'd0} + {5'd0, strength_ff, 1'b0} + {6'd0, strength_ff};

      case (pr_ff)
         2'd0:    begin opa = sx_ff; opb = sy_ff; end
         2'd1:    begin opa = sx_ff; opb = cy_ff; end
         2'd2:    begin opa = sy_ff; opb = cx_ff; end
         default: begin opa = cx_ff; opb = cy_ff; end
      endcase
      opa_mag = opa[31] ? (32'd0 - opa) : opa;
      opb_mag = opb[31] ? (32'd0 - opb) : opb;

      s_mag = alu_rsp.result[61:30];
      s_sgn = red_neg ? -$signed(s_mag) : $signed(s_mag);
      c_sgn = $signed({1'b0, u_ff});
      case (quad)
         2'd0:    begin sin_out = s_sgn;  cos_out = c_sgn;  end
         2'd1:    begin sin_out = c_sgn;  cos_out = -s_sgn; end
         2'd2:    begin sin_out = -s_sgn; cos_out = -c_sgn; end
         default: begin sin_out = -c_sgn; cos_out = s_sgn;  end
      endcase

      tl_mag    = alu_rsp.result[43:12];
      pr_mag    = alu_rsp.result[61:30];
      timer_sum = timers_ff[k_ff] + elapsed_ff;
      horner_q  = alu_rsp.result[30:0];
   end

   always_comb begin
      state_in         = state_ff;
      issued_in        = issued_ff;
      strength_in      = strength_ff;
      prev_strength_in = prev_strength_ff;
      prev_time_in     = prev_time_ff;
      timers_in        = timers_ff;
      k_in             = k_ff;
      call_in          = call_ff;
      step_in          = step_ff;
      pr_in            = pr_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_chan.ready;
      elapsed_in       = elapsed_ff;
      timer_in         = timer_ff;
      tmp_in           = tmp_ff;
      phase_in         = phase_ff;
      x_in             = x_ff;
      x2_in            = x2_ff;
      t_in             = t_ff;
      u_in             = u_ff;
      px_in            = px_ff;
      py_in            = py_ff;
      sx_in            = sx_ff;
      cx_in            = cx_ff;
      sy_in            = sy_ff;
      cy_in            = cy_ff;
      prod_in          = prod_ff;
      out_in           = out_ff;

      alu_req       = '0;
      alu_req.op    = ALU_MUL;
      is_op         = !(state_ff inside {ST_IDLE, ST_LOAD, ST_EMIT});
      alu_req.start = is_op && !issued_ff;
      if (alu_req.start) begin
         issued_in = 1'b1;
      end
      if (alu_rsp.done) begin
         issued_in = 1'b0;
      end

      if (csr_chan.valid) begin
         strength_in = csr_chan.wind_strength;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               elapsed_in   = req_chan.current_time - prev_time_ff;
               prev_time_in = req_chan.current_time;
               k_in         = 2'd0;
               state_in     = ST_LOAD;
            end
         end
         ST_LOAD: begin
            timer_in = timer_sum;
            call_in  = 2'd0;
            if (strength_ff != 16'd0) begin
               state_in = ST_RS_MUL;
            end else begin
               timers_in[k_ff] = timer_sum;
               state_in        = ST_FQ_W;
            end
         end
         ST_RS_MUL: begin
            alu_req.a = {32'd0, timer_ff};
            alu_req.b = {16'd0, prev_strength_ff};
            if (alu_rsp.done) begin
               tmp_in   = alu_rsp.result;
               state_in = ST_RS_DIV;
            end
         end
         ST_RS_DIV: begin
            alu_req.op    = ALU_DIV;
            alu_req.a     = tmp_ff;
            alu_req.b     = {16'd0, strength_ff};
            alu_req.nbits = RESCALE_DIV_BITS;
            if (alu_rsp.done) begin
               // quotient saturates at 32 bits
               if (alu_rsp.result[47:32] != 16'd0) begin
                  timer_in        = 32'hFFFF_FFFF;
                  timers_in[k_ff] = 32'hFFFF_FFFF;
               end else begin
                  timer_in        = alu_rsp.result[31:0];
                  timers_in[k_ff] = alu_rsp.result[31:0];
               end
               state_in = ST_FQ_W;
            end
         end
         ST_FQ_W: begin
            alu_req.a = {45'd0, freq20(call_ff[0], k_ff)};
            alu_req.b = {16'd0, strength_ff};
            if (alu_rsp.done) begin
               tmp_in   = alu_rsp.result;
               state_in = ST_FQ_RATE;
            end
         end
         ST_FQ_RATE: begin
            alu_req.a = tmp_ff;
            alu_req.b = {10'd0, INV_2PI_Q24};
            if (alu_rsp.done) begin
               tmp_in   = alu_rsp.result >> 24;
               state_in = ST_FQ_PH;
            end
         end
         ST_FQ_PH: begin
            alu_req.a = tmp_ff;
            alu_req.b = timer_ff;
            if (alu_rsp.done) begin
               phase_in = alu_rsp.result[45:14];
               state_in = ST_SC_M;
            end
         end
         ST_TL_MUL: begin
            alu_req.a = {42'd0, s35};
            alu_req.b = pct_mag;
            if (alu_rsp.done) begin
               tmp_in   = alu_rsp.result;
               state_in = ST_TL_DIV;
            end
         end
         ST_TL_DIV: begin
            alu_req.op    = ALU_DIV;
            alu_req.a     = tmp_ff;
            alu_req.b     = {16'd0, TILT_DIVISOR};
            alu_req.nbits = TILT_DIV_BITS;
            if (alu_rsp.done) begin
               phase_in = pct[31] ? (32'd0 - tl_mag) : tl_mag;
               state_in = ST_SC_M;
            end
         end
         ST_SC_M: begin
            // remainder turns to radians
            alu_req.a = {31'd0, TWO_PI_Q30};
            alu_req.b = red_mag;
            if (alu_rsp.done) begin
               x_in     = alu_rsp.result[61:32];
               state_in = ST_SC_X2;
            end
         end
         ST_SC_X2: begin
            alu_req.a = {34'd0, x_ff};
            alu_req.b = {2'd0, x_ff};
            if (alu_rsp.done) begin
               x2_in    = alu_rsp.result[59:30];
               t_in     = ONE_Q30;
               u_in     = ONE_Q30;
               step_in  = 3'd0;
               state_in = ST_SC_HMUL;
            end
         end
         ST_SC_HMUL: begin
            alu_req.a = {34'd0, x2_ff};
            alu_req.b = {1'b0, (step_ff[2] ? u_ff : t_ff)};
            if (alu_rsp.done) begin
               tmp_in   = alu_rsp.result >> 30;
               state_in = ST_SC_HDIV;
            end
         end
         ST_SC_HDIV: begin
            alu_req.op    = ALU_DIV;
            alu_req.a     = tmp_ff;
            alu_req.b     = {16'd0, horner_div(step_ff)};
            alu_req.nbits = HORNER_DIV_BITS;
            if (alu_rsp.done) begin
               if (step_ff[2]) begin
                  u_in = ONE_Q30 - horner_q;
               end else begin
                  t_in = ONE_Q30 - horner_q;
               end
               step_in  = step_ff + 3'd1;
               state_in = (step_ff == 3'd7) ? ST_SC_S : ST_SC_HMUL;
            end
         end
         ST_SC_S: begin
            alu_req.a = {34'd0, x_ff};
            alu_req.b = {1'b0, t_ff};
            if (alu_rsp.done) begin
               call_in = call_ff + 2'd1;
               case (call_ff)
                  2'd0: begin
                     px_in    = sin_out;
                     state_in = ST_FQ_W;
                  end
                  2'd1: begin
                     py_in    = cos_out;
                     state_in = ST_TL_MUL;
                  end
                  2'd2: begin
                     sx_in    = sin_out;
                     cx_in    = cos_out;
                     state_in = ST_TL_MUL;
                  end
                  default: begin
                     sy_in    = sin_out;
                     cy_in    = cos_out;
                     pr_in    = 2'd0;
                     state_in = ST_PR_MUL;
                  end
               endcase
            end
         end
         ST_PR_MUL: begin
            alu_req.a = {32'd0, opa_mag};
            alu_req.b = opb_mag;
            if (alu_rsp.done) begin
               prod_in[pr_ff] = (opa[31] ^ opb[31]) ? -$signed(pr_mag) : $signed(pr_mag);
               pr_in    = pr_ff + 2'd1;
               state_in = (pr_ff == 2'd3) ? ST_EMIT : ST_PR_MUL;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in           = 1'b1;
               out_in.matrix_index    = k_ff;
               out_in.cos_tilt_y      = to_out(cy_ff);
               out_in.neg_sin_tilt_y  = to_out(-sy_ff);
               out_in.sinx_times_siny = to_out(prod_ff[0]);
               out_in.cos_tilt_x      = to_out(cx_ff);
               out_in.sinx_times_cosy = to_out(prod_ff[1]);
               out_in.siny_times_cosx = to_out(prod_ff[2]);
               out_in.neg_sin_tilt_x  = to_out(-sx_ff);
               out_in.cosx_times_cosy = to_out(prod_ff[3]);
               out_in.last_matrix     = (k_ff == LAST_K);
               if (k_ff == LAST_K) begin
                  prev_strength_in = strength_ff;
                  state_in         = ST_IDLE;
               end else begin
                  k_in     = k_ff + 2'd1;
                  state_in = ST_LOAD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         issued_ff        <= 1'b0;
         strength_ff      <= '0;
         prev_strength_ff <= '0;
         prev_time_ff     <= '0;
         timers_ff        <= '{default: '0};
         k_ff             <= '0;
         call_ff          <= '0;
         step_ff          <= '0;
         pr_ff            <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         issued_ff        <= issued_in;
         strength_ff      <= strength_in;
         prev_strength_ff <= prev_strength_in;
         prev_time_ff     <= prev_time_in;
         timers_ff        <= timers_in;
         k_ff             <= k_in;
         call_ff          <= call_in;
         step_ff          <= step_in;
         pr_ff            <= pr_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      elapsed_ff <= elapsed_in;
      timer_ff   <= timer_in;
      tmp_ff     <= tmp_in;
      phase_ff   <= phase_in;
      x_ff       <= x_in;
      x2_ff      <= x2_in;
      t_ff       <= t_in;
      u_ff       <= u_in;
      px_ff      <= px_in;
      py_ff      <= py_in;
      sx_ff      <= sx_in;
      cx_ff      <= cx_in;
      sy_ff      <= sy_in;
      cy_ff      <= cy_in;
      prod_ff    <= prod_in;
      out_ff     <= out_in;
   end

endmodule

`default_nettype wire

FILE: test/wind_sway_rotation_matrices_tb.sv
// Self-checking bench for wind_sway_rotation_matrices: time words in, matrix words out.
// Predicts every matrix word in fixed point and checks it. Depends on wsr_pkg and wsr_channels.
`timescale 1ns / 100ps

module wind_sway_rotation_matrices_tb;
   import wsr_pkg::*;

   localparam int CYCLE_LIMIT = 30_000_000;
   localparam int HOLD_CYCLES = 40_000;
   localparam logic [63:0] TURN_Q30 = 64'd6746518852;
   localparam logic [63:0] INV_TURN_Q24 = 64'd2670177;
   localparam logic [63:0] UNIT_Q30 = 64'd1073741824;

   typedef struct packed {
      logic [1:0]  matrix_index;
      logic [15:0] cos_tilt_y;
      logic [15:0] neg_sin_tilt_y;
      logic [15:0] sinx_times_siny;
      logic [15:0] cos_tilt_x;
      logic [15:0] sinx_times_cosy;
      logic [15:0] siny_times_cosx;
      logic [15:0] neg_sin_tilt_x;
      logic [15:0] cosx_times_cosy;
      logic        last_matrix;
   } matrix_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   wsr_req_if req_bus ();
   wsr_rsp_if rsp_bus ();
   wsr_csr_if csr_bus ();

   wind_sway_rotation_matrices DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   always #10 clock = ~clock;

   // predictor state
   logic [15:0] sway_strength = '0;
   logic [15:0] prior_strength = '0;
   logic [31:0] prior_time = '0;
   logic [31:0] sway_timers [4] = '{default: '0};
   logic [63:0] freq_x_q16 [4] = '{64'd9830, 64'd16384, 64'd12452, 64'd9830};
   logic [63:0] freq_y_q16 [4] = '{64'd11141, 64'd9830, 64'd3277, 64'd14418};

   logic [31:0]     pending_times [$];
   matrix_word_type expected_words [$];
   int  failures = 0;
   int  words_checked = 0;
   bit  calm = 1'b0;
   bit  hold_done = 1'b0;

   function automatic void sin_cos(input logic [31:0] p, output longint s_out,
                                   output longint c_out);
      logic [1:0]  q;
      logic [31:0] d, nd;
      logic [63:0] m, x, x2, t, u;
      longint      s, c;
      q = 2'((p + 32'h2000_0000) >> 30);
      d = p - {q, 30'b0};
      nd = -d;
      m = d[31] ? {32'b0, nd} : {32'b0, d};
      x = (m * TURN_Q30) >> 32;
      x2 = (x * x) >> 30;
      t = UNIT_Q30 - x2 / 72;
      u = UNIT_Q30 - x2 / 56;
      t = UNIT_Q30 - ((x2 * t) >> 30) / 42;
      t = UNIT_Q30 - ((x2 * t) >> 30) / 20;
      t = UNIT_Q30 - ((x2 * t) >> 30) / 6;
      u = UNIT_Q30 - ((x2 * u) >> 30) / 30;
      u = UNIT_Q30 - ((x2 * u) >> 30) / 12;
      u = UNIT_Q30 - ((x2 * u) >> 30) / 2;
      s = longint'((x * t) >> 30);
      if (d[31]) s = -s;
      c = longint'(u);
      case (q)
         2'd0: begin s_out = s;  c_out = c;  end
         2'd1: begin s_out = c;  c_out = -s; end
         2'd2: begin s_out = -s; c_out = -c; end
         default: begin s_out = -c; c_out = s; end
      endcase
   endfunction

   function automatic longint mul_q30(input longint a, input longint b);
      logic [63:0] ma, mb, r;
      ma = a < 0 ? -a : a;
      mb = b < 0 ? -b : b;
      r = (ma * mb) >> 30;
      return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
   endfunction

   function automatic logic [15:0] to_q15(input longint v);
      logic [63:0] m, lim, r;
      m = v < 0 ? -v : v;
      lim = v < 0 ? 64'd32768 : 64'd32767;
      m = (m + 64'd16384) >> 15;
      if (m > lim) m = lim;
      r = v < 0 ? -m : m;
      return r[15:0];
   endfunction

   function automatic logic [31:0] sway_phase(input logic [31:0] timer, input logic [63:0] f);
      logic [63:0] w, rate, prod;
      w = {48'b0, sway_strength} * 64'd20 * f;
      rate = (w * INV_TURN_Q24) >> 24;
      prod = rate * {32'b0, timer};
      return prod[45:14];
   endfunction

   function automatic logic [31:0] tilt_turns(input longint pct);
      logic [63:0] m, mag;
      m = pct < 0 ? -pct : pct;
      mag = (({48'b0, sway_strength} * 64'd35 * m) / 64'd360) >> 12;
      return pct < 0 ? -mag[31:0] : mag[31:0];
   endfunction

   function automatic void predict_matrices(input logic [31:0] now);
      logic [31:0]     elapsed;
      logic [63:0]     scaled;
      longint          px, py, unused, sx, cx, sy, cy;
      matrix_word_type w;
      elapsed = now - prior_time;
      prior_time = now;
      for (int k = 0; k < 4; k++) begin
         sway_timers[k] = sway_timers[k] + elapsed;
         if (sway_strength != 0) begin
            scaled = ({32'b0, sway_timers[k]} * {48'b0, prior_strength}) /
                     {48'b0, sway_strength};
            sway_timers[k] = scaled > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : scaled[31:0];
         end
         sin_cos(sway_phase(sway_timers[k], freq_x_q16[k]), px, unused);
         sin_cos(sway_phase(sway_timers[k], freq_y_q16[k]), unused, py);
         sin_cos(tilt_turns(px), sx, cx);
         sin_cos(tilt_turns(py), sy, cy);
         w.matrix_index    = 2'(k);
         w.cos_tilt_y      = to_q15(cy);
         w.neg_sin_tilt_y  = to_q15(-sy);
         w.sinx_times_siny = to_q15(mul_q30(sx, sy));
         w.cos_tilt_x      = to_q15(cx);
         w.sinx_times_cosy = to_q15(mul_q30(sx, cy));
         w.siny_times_cosx = to_q15(mul_q30(sy, cx));
         w.neg_sin_tilt_x  = to_q15(-sx);
         w.cosx_times_cosy = to_q15(mul_q30(cx, cy));
         w.last_matrix     = (k == 3);
         expected_words.push_back(w);
      end
      prior_strength = sway_strength;
   endfunction

   // time word driver
   int req_gap = 0;
   initial begin
      req_bus.valid = 1'b0;
      req_bus.current_time = '0;
      csr_bus.valid = 1'b0;
      csr_bus.wind_strength = '0;
      rsp_bus.ready = 1'b0;
   end

   always @(posedge clock) begin
      int g;
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_gap <= 0;
      end else if (req_bus.valid && req_bus.ready) begin
         predict_matrices(req_bus.current_time);
         g = calm ? 0 : $urandom_range(0, 12);
         if (g == 0 && pending_times.size() > 0) begin
            req_bus.current_time <= pending_times.pop_front();
         end else begin
            req_bus.valid <= 1'b0;
         end
         req_gap <= g;
      end else if (!req_bus.valid) begin
         if (req_gap > 0) begin
            req_gap <= req_gap - 1;
         end else if (pending_times.size() > 0) begin
            req_bus.valid <= 1'b1;
            req_bus.current_time <= pending_times.pop_front();
         end
      end
   end

   // long receiver hold-off, timed on its own
   int rsp_hold = 0;
   bit hold_over = 1'b0;
   always @(posedge clock) begin
      if (hold_done && !hold_over) begin
         if (rsp_hold >= HOLD_CYCLES) begin
            hold_over <= 1'b1;
         end else begin
            rsp_hold <= rsp_hold + 1;
         end
      end
   end

   // matrix word monitor
   int rsp_stall = 0;
   always @(posedge clock) begin
      matrix_word_type got, exp_w;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_stall <= 0;
      end else if (rsp_bus.valid && rsp_bus.ready) begin
         got = '{rsp_bus.matrix_index, rsp_bus.cos_tilt_y, rsp_bus.neg_sin_tilt_y,
                 rsp_bus.sinx_times_siny, rsp_bus.cos_tilt_x, rsp_bus.sinx_times_cosy,
                 rsp_bus.siny_times_cosx, rsp_bus.neg_sin_tilt_x,
                 rsp_bus.cosx_times_cosy, rsp_bus.last_matrix};
         if (expected_words.size() == 0) begin
            failures++;
            $display("%0t: unexpected word idx=%0d", $time, got.matrix_index);
         end else begin
            exp_w = expected_words.pop_front();
            if (got !== exp_w) begin
               failures++;
               $display("%0t: mismatch exp idx=%0d %h %h %h %h %h %h %h %h last=%0d",
                        $time, exp_w.matrix_index, exp_w.cos_tilt_y,
                        exp_w.neg_sin_tilt_y, exp_w.sinx_times_siny, exp_w.cos_tilt_x,
                        exp_w.sinx_times_cosy, exp_w.siny_times_cosx,
                        exp_w.neg_sin_tilt_x, exp_w.cosx_times_cosy, exp_w.last_matrix);
               $display("%0t:          got idx=%0d %h %h %h %h %h %h %h %h last=%0d",
                        $time, got.matrix_index, got.cos_tilt_y, got.neg_sin_tilt_y,
                        got.sinx_times_siny, got.cos_tilt_x, got.sinx_times_cosy,
                        got.siny_times_cosx, got.neg_sin_tilt_x, got.cosx_times_cosy,
                        got.last_matrix);
            end
         end
         words_checked++;
         // one long hold-off so the block backs up and stalls its input
         if (words_checked == 40 && !hold_done) begin
            hold_done <= 1'b1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_stall <= calm ? 0 : $urandom_range(0, 12);
            if (!calm && $urandom_range(0, 1)) rsp_bus.ready <= 1'b0;
         end
      end else if (!rsp_bus.ready) begin
         if (!hold_done || hold_over) begin
            if (rsp_stall > 0) rsp_stall <= rsp_stall - 1;
            else rsp_bus.ready <= 1'b1;
         end
      end
   end

   int cycles = 0;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic drain_block();
      wait (pending_times.size() == 0 && !req_bus.valid && expected_words.size() == 0);
      repeat (50) @(posedge clock);
   endtask

   task automatic write_strength(input logic [15:0] value);
      @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.wind_strength <= value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      sway_strength = value;
      csr_bus.valid <= 1'b0;
   endtask

   task automatic run_phase(input logic [15:0] strength, input logic [31:0] times [$]);
      write_strength(strength);
      foreach (times[i]) pending_times.push_back(times[i]);
      drain_block();
   endtask

   initial begin
      logic [31:0] batch [$];
      logic [31:0] t;
      logic [15:0] s;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      // first nonzero strength after reset zeroes the timers; wrap and backwards time
      run_phase(16'd16384, '{32'h0, 32'h0001_0000, 32'h0001_8000, 32'hFFFF_FFFF, 32'h0,
                             32'h7FFF_FFFF, 32'h1000_0000});
      // zero strength gives identity matrices
      run_phase(16'd0, '{32'h0002_0000, 32'h0003_0000});
      run_phase(16'd65535, '{32'h0100_0000, 32'h8000_0000, 32'hC000_0000});
      // big old strength over tiny new one saturates the rescale
      run_phase(16'd1, '{32'hC001_0000, 32'h5555_5555});
      run_phase(16'd65535, '{32'hC002_0000, 32'hFFFF_0000, 32'hAAAA_AAAA});
      t = 32'hFFFF_0000;
      for (int ph = 0; ph < 8; ph++) begin
         calm = (ph == 3);
         case (ph)
            0: s = 16'hFFFF;
            1: s = 16'd0;
            2: s = 16'd1;
            default: s = 16'($urandom_range(0, 65535));
         endcase
         batch.delete();
         for (int i = 0; i < 23; i++) begin
            if ($urandom_range(0, 4) == 0) t = $urandom;
            else t = t + 32'($urandom_range(1, 32'h2000));
            batch.push_back(t);
         end
         run_phase(s, batch);
      end
      calm = 1'b0;
      repeat (200) @(posedge clock);
      if (failures == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
